// ----- rtl/bresenham_line_rasterizer_styled_macros.svh -----
// Assertion macros shared by the styled line rasterizer RTL.
`ifndef BRESENHAM_LINE_RASTERIZER_STYLED_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_STYLED_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brl: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brl: next-cycle check failed");

`endif

// ----- rtl/brl_pkg.sv -----
// Types, constants and residue functions for the styled line rasterizer.
package brl_pkg;

  localparam int COORD_BITS = 11;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int TMD_BITS   = COORD_BITS + 2;
  localparam int DEC_BITS   = COORD_BITS + 3;

  localparam int DOT_PERIOD  = 6;
  localparam int DASH_PERIOD = 10;
  localparam int DASH_ON     = 5;

  localparam int MOD_BITS = (COORD_BITS > 10) ? COORD_BITS - 3 : 7;
  localparam int TOP_MOD6 = (DOT_PERIOD - (2 ** (COORD_BITS - 1)) % DOT_PERIOD) % DOT_PERIOD;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;
  typedef logic [TMD_BITS-1:0]          tmd_t;
  typedef logic [MOD_BITS-1:0]          modsum_t;
  typedef logic [2:0]                   res6_t;
  typedef logic [3:0]                   res10_t;

  typedef enum logic [1:0] {
    STYLE_SIMPLE = 2'd0,
    STYLE_DOTTED = 2'd1,
    STYLE_DASHED = 2'd2,
    STYLE_THICK  = 2'd3
  } style_t;

  // Mathematical residue (0 to 5) of a signed coordinate modulo the dot period.
  function automatic res6_t mod6_signed(coord_t m);
    modsum_t v;
    v = modsum_t'(m[4:0]) + (modsum_t'(m[COORD_BITS-2:5]) << 1)
      + (m[COORD_BITS-1] ? modsum_t'(TOP_MOD6) : '0);
    for (int i = MOD_BITS - 3; i >= 0; i--) begin
      if (v >= (modsum_t'(DOT_PERIOD) << i)) begin
        v = v - (modsum_t'(DOT_PERIOD) << i);
      end
    end
    return res6_t'(v);
  endfunction

  // Residue of the absolute value of a signed coordinate modulo the dash period.
  function automatic res10_t mod10_abs(coord_t m);
    logic [COORD_BITS-1:0] mu;
    logic [COORD_BITS-1:0] a;
    modsum_t v;
    mu = m;
    a  = m[COORD_BITS-1] ? (~mu + 1'b1) : mu;
    v  = modsum_t'(a[4:0]) + (modsum_t'(a[COORD_BITS-1:5]) << 1);
    for (int i = MOD_BITS - 4; i >= 0; i--) begin
      if (v >= (modsum_t'(DASH_PERIOD) << i)) begin
        v = v - (modsum_t'(DASH_PERIOD) << i);
      end
    end
    return res10_t'(v);
  endfunction

endpackage

// ----- rtl/brl_in_if.sv -----
// Input channel interface: load and step commands for the line rasterizer.
interface brl_in_if import brl_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       op;
  coord_t     start_x;
  coord_t     start_y;
  coord_t     end_x;
  coord_t     end_y;
  logic [1:0] style;

  modport source (output valid, op, start_x, start_y, end_x, end_y, style, input ready);
  modport sink   (input valid, op, start_x, start_y, end_x, end_y, style, output ready);
endinterface

// ----- rtl/brl_out_if.sv -----
// Result channel interface: one rasterized pixel per transaction.
interface brl_out_if import brl_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   plotted;
  logic   wide;
  logic   last;

  modport source (output valid, pixel_x, pixel_y, plotted, wide, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, plotted, wide, last, output ready);
endinterface

// ----- rtl/bresenham_line_rasterizer_styled.sv -----
// Styled Bresenham line rasterizer: load and step commands in, pixels out.
//
// The in_chan channel carries commands. A load transaction (op = 0) sets up a
// new line from two endpoints and a style and produces no pixel. A step
// transaction (op = 1) produces the next pixel of the active line on out_chan,
// with plotted, wide and last flags. A step with no active line is consumed
// and produces nothing; after the pixel marked last the line is inactive.
// The pixel of a step accepted at one edge is registered and is valid on
// out_chan from that edge on. One transaction is accepted every cycle while
// in_chan.ready is high; each pixel takes a single decision-variable update,
// computed from the state registers and written back into them.
// in_chan.ready is high while the output register is empty or being taken, so
// a stalled receiver holds the pending pixel and stops new commands until it
// takes that pixel.
// Reset (rst_n low at a clock edge) empties the output register and leaves
// no line active.
module bresenham_line_rasterizer_styled import brl_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  brl_in_if.sink    in_chan,
  brl_out_if.source out_chan
);

`include "bresenham_line_rasterizer_styled_macros.svh"

  coord_t cur_major_r, cur_major_nxt;
  coord_t cur_minor_r, cur_minor_nxt;
  coord_t major_end_r, major_end_nxt;
  dec_t   decision_r, decision_nxt;
  tmd_t   twice_minor_delta_r, twice_minor_delta_nxt;
  dec_t   twice_minor_minus_major_r, twice_minor_minus_major_nxt;
  logic   minor_direction_r, minor_direction_nxt;
  logic   axes_swapped_r, axes_swapped_nxt;
  style_t line_style_r, line_style_nxt;
  res6_t  dot_res_r, dot_res_nxt;
  res10_t dash_res_r, dash_res_nxt;
  logic   line_active_r, line_active_nxt;
  logic   first_pending_r, first_pending_nxt;

  logic   out_valid_r, out_valid_nxt;
  coord_t out_pixel_x_r, out_pixel_x_nxt;
  coord_t out_pixel_y_r, out_pixel_y_nxt;
  logic   out_plotted_r, out_plotted_nxt;
  logic   out_wide_r, out_wide_nxt;
  logic   out_last_r, out_last_nxt;

  logic in_fire;
  logic load_fire;
  logic step_fire;

  diff_t                 diff_x, diff_y;
  logic [COORD_BITS-1:0] abs_dx, abs_dy, dmaj, dmin;
  logic                  ld_swap, ld_reverse;
  coord_t                maj0, min0, maj1, min1;
  coord_t                ld_minor_end;
  res6_t                 r6_sx, r6_sy, r6_ex, r6_ey, r6_a0, r6_a1;
  res10_t                r10_sx, r10_sy, r10_ex, r10_ey, r10_a0, r10_a1;
  dec_t                  dmaj_s, dmin_s;

  coord_t step_major, step_minor;
  res6_t  step_dot;
  res10_t step_dash;
  logic   step_last;
  logic   step_plot;

  assign in_fire   = in_chan.valid && in_chan.ready;
  assign load_fire = in_fire && (in_chan.op == OP_LOAD);
  assign step_fire = in_fire && (in_chan.op == OP_STEP) && line_active_r;

  assign in_chan.ready    = !out_valid_r || out_chan.ready;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.pixel_x = out_pixel_x_r;
  assign out_chan.pixel_y = out_pixel_y_r;
  assign out_chan.plotted = out_plotted_r;
  assign out_chan.wide    = out_wide_r;
  assign out_chan.last    = out_last_r;

  always_comb begin
    diff_x  = diff_t'(in_chan.end_x) - diff_t'(in_chan.start_x);
    diff_y  = diff_t'(in_chan.end_y) - diff_t'(in_chan.start_y);
    abs_dx  = diff_x[DIFF_BITS-1] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
    abs_dy  = diff_y[DIFF_BITS-1] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
    ld_swap = abs_dy > abs_dx;

    r6_sx  = mod6_signed(in_chan.start_x);
    r6_sy  = mod6_signed(in_chan.start_y);
    r6_ex  = mod6_signed(in_chan.end_x);
    r6_ey  = mod6_signed(in_chan.end_y);
    r10_sx = mod10_abs(in_chan.start_x);
    r10_sy = mod10_abs(in_chan.start_y);
    r10_ex = mod10_abs(in_chan.end_x);
    r10_ey = mod10_abs(in_chan.end_y);

    maj0   = ld_swap ? in_chan.start_y : in_chan.start_x;
    min0   = ld_swap ? in_chan.start_x : in_chan.start_y;
    maj1   = ld_swap ? in_chan.end_y : in_chan.end_x;
    min1   = ld_swap ? in_chan.end_x : in_chan.end_y;
    dmaj   = ld_swap ? abs_dy : abs_dx;
    dmin   = ld_swap ? abs_dx : abs_dy;
    r6_a0  = ld_swap ? r6_sy : r6_sx;
    r6_a1  = ld_swap ? r6_ey : r6_ex;
    r10_a0 = ld_swap ? r10_sy : r10_sx;
    r10_a1 = ld_swap ? r10_ey : r10_ex;

    ld_reverse   = maj1 < maj0;
    ld_minor_end = ld_reverse ? min0 : min1;
    dmaj_s       = dec_t'(dmaj);
    dmin_s       = dec_t'(dmin);
  end

  always_comb begin
    step_major = first_pending_r ? cur_major_r : cur_major_r + coord_t'(1);
    if (first_pending_r || decision_r[DEC_BITS-1]) begin
      step_minor = cur_minor_r;
    end else if (minor_direction_r) begin
      step_minor = cur_minor_r - coord_t'(1);
    end else begin
      step_minor = cur_minor_r + coord_t'(1);
    end

    if (first_pending_r) begin
      step_dot = dot_res_r;
    end else if (dot_res_r == res6_t'(DOT_PERIOD - 1)) begin
      step_dot = '0;
    end else begin
      step_dot = dot_res_r + res6_t'(1);
    end

    if (first_pending_r) begin
      step_dash = dash_res_r;
    end else if (cur_major_r[COORD_BITS-1]) begin
      step_dash = (dash_res_r == '0) ? res10_t'(DASH_PERIOD - 1) : dash_res_r - res10_t'(1);
    end else begin
      step_dash = (dash_res_r == res10_t'(DASH_PERIOD - 1)) ? '0 : dash_res_r + res10_t'(1);
    end

    step_last = step_major == major_end_r;

    unique case (line_style_r)
      STYLE_DOTTED: step_plot = step_dot == '0;
      STYLE_DASHED: step_plot = step_dash < res10_t'(DASH_ON);
      STYLE_SIMPLE: step_plot = 1'b1;
      STYLE_THICK:  step_plot = 1'b1;
      default:      step_plot = 1'b1;
    endcase
  end

  always_comb begin
    cur_major_nxt               = cur_major_r;
    cur_minor_nxt               = cur_minor_r;
    major_end_nxt               = major_end_r;
    decision_nxt                = decision_r;
    twice_minor_delta_nxt       = twice_minor_delta_r;
    twice_minor_minus_major_nxt = twice_minor_minus_major_r;
    minor_direction_nxt         = minor_direction_r;
    axes_swapped_nxt            = axes_swapped_r;
    line_style_nxt              = line_style_r;
    dot_res_nxt                 = dot_res_r;
    dash_res_nxt                = dash_res_r;
    line_active_nxt             = line_active_r;
    first_pending_nxt           = first_pending_r;

    if (load_fire) begin
      cur_major_nxt               = ld_reverse ? maj1 : maj0;
      cur_minor_nxt               = ld_reverse ? min1 : min0;
      major_end_nxt               = ld_reverse ? maj0 : maj1;
      minor_direction_nxt         = ld_minor_end < (ld_reverse ? min1 : min0);
      axes_swapped_nxt            = ld_swap;
      twice_minor_delta_nxt       = tmd_t'(dmin) << 1;
      twice_minor_minus_major_nxt = (dmin_s - dmaj_s) <<< 1;
      decision_nxt                = dmin_s + dmin_s - dmaj_s;
      line_style_nxt              = style_t'(in_chan.style);
      dot_res_nxt                 = ld_reverse ? r6_a1 : r6_a0;
      dash_res_nxt                = ld_reverse ? r10_a1 : r10_a0;
      line_active_nxt             = 1'b1;
      first_pending_nxt           = 1'b1;
    end else if (step_fire) begin
      cur_major_nxt     = step_major;
      cur_minor_nxt     = step_minor;
      dot_res_nxt       = step_dot;
      dash_res_nxt      = step_dash;
      first_pending_nxt = 1'b0;
      line_active_nxt   = !step_last;
      if (!first_pending_r) begin
        decision_nxt = decision_r[DEC_BITS-1] ? decision_r + dec_t'(twice_minor_delta_r)
                                              : decision_r + twice_minor_minus_major_r;
      end
    end
  end

  always_comb begin
    out_pixel_x_nxt = out_pixel_x_r;
    out_pixel_y_nxt = out_pixel_y_r;
    out_plotted_nxt = out_plotted_r;
    out_wide_nxt    = out_wide_r;
    out_last_nxt    = out_last_r;
    if (step_fire) begin
      out_valid_nxt   = 1'b1;
      out_pixel_x_nxt = axes_swapped_r ? step_minor : step_major;
      out_pixel_y_nxt = axes_swapped_r ? step_major : step_minor;
      out_plotted_nxt = step_plot || first_pending_r;
      out_wide_nxt    = line_style_r == STYLE_THICK;
      out_last_nxt    = step_last;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r   <= 1'b0;
      first_pending_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      line_active_r   <= line_active_nxt;
      first_pending_r <= first_pending_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_major_r               <= cur_major_nxt;
    cur_minor_r               <= cur_minor_nxt;
    major_end_r               <= major_end_nxt;
    decision_r                <= decision_nxt;
    twice_minor_delta_r       <= twice_minor_delta_nxt;
    twice_minor_minus_major_r <= twice_minor_minus_major_nxt;
    minor_direction_r         <= minor_direction_nxt;
    axes_swapped_r            <= axes_swapped_nxt;
    line_style_r              <= line_style_nxt;
    dot_res_r                 <= dot_res_nxt;
    dash_res_r                <= dash_res_nxt;
    out_pixel_x_r             <= out_pixel_x_nxt;
    out_pixel_y_r             <= out_pixel_y_nxt;
    out_plotted_r             <= out_plotted_nxt;
    out_wide_r                <= out_wide_nxt;
    out_last_r                <= out_last_nxt;
  end

  `BRL_ASSERT_NEXT(a_idle_step_silent, clk, rst_n, in_fire && (in_chan.op == OP_STEP) && !line_active_r, !out_valid_r)
  `BRL_ASSERT_NEXT(a_load_arms_line, clk, rst_n, load_fire, line_active_r && first_pending_r)
  `BRL_ASSERT_SAME(a_first_needs_line, clk, rst_n, first_pending_r, line_active_r)
  `BRL_ASSERT_NEXT(a_last_ends_line, clk, rst_n, step_fire && step_last, !line_active_r && out_valid_r && out_last_r)

endmodule
